// ===== rtl/rpn_pkg.sv =====
// Shared constants, codes and control structs of the RPN stack calculator.
// No dependencies; imported by every module of the block.
package rpn_pkg;

  localparam int DATA_W            = 64;
  localparam int ACT_W             = 3;
  localparam int DEPTH_W           = 7;
  localparam int STAT_W            = 3;
  localparam int OUT_W             = 80;
  localparam int DEF_STACK_DEPTH   = 64;
  localparam int DEF_FRACTION_BITS = 32;

  localparam logic [ACT_W-1:0] ACT_PUSH  = 3'd0;
  localparam logic [ACT_W-1:0] ACT_ADD   = 3'd1;
  localparam logic [ACT_W-1:0] ACT_SUB   = 3'd2;
  localparam logic [ACT_W-1:0] ACT_MUL   = 3'd3;
  localparam logic [ACT_W-1:0] ACT_DIV   = 3'd4;
  localparam logic [ACT_W-1:0] ACT_CLEAR = 3'd5;

  localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
  localparam logic [STAT_W-1:0] ST_UNDERFLOW = 3'd1;
  localparam logic [STAT_W-1:0] ST_FULL      = 3'd2;
  localparam logic [STAT_W-1:0] ST_DIVZERO   = 3'd3;
  localparam logic [STAT_W-1:0] ST_RANGE     = 3'd4;

  // Request to the serial multiply/divide unit
  typedef struct packed {
    logic start;
    logic div;
  } md_ctrl_t;

  // Completion report of the serial multiply/divide unit
  typedef struct packed {
    logic done;
    logic ok;
  } md_stat_t;

endpackage

// ===== rtl/rpn_stack_calculator.sv =====
// Flow: push, clear and words rejected on acceptance go straight to the response state; the
// operators pass the execute state first, where multiply (64 shift-add steps) and divide
// (restoring steps) start the serial unit and wait for its report in the wait state.
// Throughput: one word at a time, taken the cycle after the previous result is loaded.
// Reset: asynchronous, active low; clears depth, error and handshake state. Stack contents
// stay undefined and are never read before being written, so there is no clearing pass.
module rpn_stack_calculator import rpn_pkg::*; #(
  parameter int STACK_DEPTH   = DEF_STACK_DEPTH,
  parameter int FRACTION_BITS = DEF_FRACTION_BITS
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [DATA_W-1:0]   s_axis_tdata,  // [63:0] operand_value
  input  logic [ACT_W-1:0]    s_axis_tuser,  // [2:0] action
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OUT_W-1:0]    m_axis_tdata   // [63:0] top_value, [70:64] stack_depth,
                                             // [73:71] status, [79:74] zero
);

  localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
  localparam int ADDR_W = $clog2(STACK_DEPTH);

  // Sequencer states
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_WAIT = 2'd2;
  localparam logic [1:0] S_RESP = 2'd3;

  logic [1:0]        state_q, state_d;
  logic [ACT_W-1:0]  act_q, act_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [STAT_W-1:0] err_q, err_d;
  logic [DATA_W-1:0] top_q, top_d;
  logic              out_valid_q, out_valid_d;
  logic [OUT_W-1:0]  out_data_q, out_data_d;

  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr, rd_addr;
  logic [DATA_W-1:0] wr_data, next_val;
  logic [CNT_W-1:0]  cnt_less2;

  md_ctrl_t          md_ctrl;
  md_stat_t          md_stat;
  logic [DATA_W-1:0] md_res;

  logic [DATA_W-1:0] sum, dif;
  logic              add_ok, sub_ok;
  logic [31:0]       cnt_wide;
  logic [DATA_W-1:0] shown_top;

  // The entry below the top is read every cycle; it is valid in the cycle after acceptance
  assign cnt_less2 = cnt_q - CNT_W'(2);
  assign rd_addr   = cnt_less2[ADDR_W-1:0];

  rpn_stack #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_addr_i (rd_addr),
    .rd_data_o (next_val)
  );

  rpn_muldiv #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_muldiv (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (md_ctrl),
    .a_i    (next_val),
    .b_i    (top_q),
    .stat_o (md_stat),
    .res_o  (md_res)
  );

  // Exact add and subtract: overflow shows as a sign that neither operand explains
  assign sum    = next_val + top_q;
  assign dif    = next_val - top_q;
  assign add_ok = ~((next_val[DATA_W-1] ^ sum[DATA_W-1]) & (top_q[DATA_W-1] ^ sum[DATA_W-1]));
  assign sub_ok = ~((next_val[DATA_W-1] ^ top_q[DATA_W-1]) &
                    (next_val[DATA_W-1] ^ dif[DATA_W-1]));

  assign cnt_wide  = 32'(cnt_q);
  assign shown_top = (cnt_q != '0) ? top_q : '0;

  always_comb begin
    state_d     = state_q;
    act_d       = act_q;
    cnt_d       = cnt_q;
    err_d       = err_q;
    top_d       = top_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_data_d  = out_data_q;
    wr_en       = 1'b0;
    wr_addr     = rd_addr;
    wr_data     = s_axis_tdata;
    md_ctrl     = '0;

    unique case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          act_d   = s_axis_tuser;
          state_d = S_RESP;
          priority if (s_axis_tuser == ACT_CLEAR) begin
            cnt_d = '0;
            err_d = ST_OK;
          end else if ((err_q != ST_OK) || (s_axis_tuser > ACT_CLEAR)) begin
            // hold everything: sticky error or unused code
          end else if (s_axis_tuser == ACT_PUSH) begin
            if (cnt_q == CNT_W'(STACK_DEPTH)) begin
              err_d = ST_FULL;
            end else begin
              wr_en   = 1'b1;
              wr_addr = cnt_q[ADDR_W-1:0];
              wr_data = s_axis_tdata;
              top_d   = s_axis_tdata;
              cnt_d   = cnt_q + 1'b1;
            end
          end else if (cnt_q < CNT_W'(2)) begin
            err_d = ST_UNDERFLOW;
          end else begin
            state_d = S_EXEC;
          end
        end
      end

      S_EXEC: begin
        state_d = S_RESP;
        unique case (act_q)
          ACT_ADD: begin
            if (add_ok) begin
              wr_en   = 1'b1;
              wr_data = sum;
              top_d   = sum;
              cnt_d   = cnt_q - 1'b1;
            end else begin
              err_d = ST_RANGE;
            end
          end
          ACT_SUB: begin
            if (sub_ok) begin
              wr_en   = 1'b1;
              wr_data = dif;
              top_d   = dif;
              cnt_d   = cnt_q - 1'b1;
            end else begin
              err_d = ST_RANGE;
            end
          end
          ACT_MUL: begin
            md_ctrl.start = 1'b1;
            state_d       = S_WAIT;
          end
          ACT_DIV: begin
            if (top_q == '0) begin
              err_d = ST_DIVZERO;
            end else begin
              md_ctrl.start = 1'b1;
              md_ctrl.div   = 1'b1;
              state_d       = S_WAIT;
            end
          end
          default: ;
        endcase
      end

      S_WAIT: begin
        if (md_stat.done) begin
          state_d = S_RESP;
          if (md_stat.ok) begin
            wr_en   = 1'b1;
            wr_data = md_res;
            top_d   = md_res;
            cnt_d   = cnt_q - 1'b1;
          end else begin
            err_d = ST_RANGE;
          end
        end
      end

      S_RESP: begin
        // Load the result word once the output register is free
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d = 1'b1;
          out_data_d  = {{(OUT_W-DATA_W-DEPTH_W-STAT_W){1'b0}}, err_q,
                         cnt_wide[DEPTH_W-1:0], shown_top};
          state_d     = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      err_q       <= ST_OK;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      err_q       <= err_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers: no reset
  always_ff @(posedge clk_i) begin
    act_q      <= act_d;
    top_q      <= top_d;
    out_data_q <= out_data_d;
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

// ===== rtl/rpn_stack.sv =====
// Operand stack storage: one write port, one registered read port.
// Depends on rpn_pkg for the data width and the default depth.
module rpn_stack import rpn_pkg::*; #(
  parameter int STACK_DEPTH = DEF_STACK_DEPTH,
  localparam int ADDR_W = $clog2(STACK_DEPTH)
) (
  input  logic              clk_i,
  input  logic              wr_en_i,
  input  logic [ADDR_W-1:0] wr_addr_i,
  input  logic [DATA_W-1:0] wr_data_i,
  input  logic [ADDR_W-1:0] rd_addr_i,
  output logic [DATA_W-1:0] rd_data_o
);

  logic [DATA_W-1:0] mem [STACK_DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    rd_data_o <= mem[rd_addr_i];
  end

endmodule

// ===== rtl/rpn_muldiv.sv =====
// Bit-serial signed fixed-point multiplier (shift-add) and divider (restoring).
// Depends on rpn_pkg for widths and the request/report structs.
module rpn_muldiv import rpn_pkg::*; #(
  parameter int FRACTION_BITS = DEF_FRACTION_BITS
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  md_ctrl_t          ctrl_i,
  input  logic [DATA_W-1:0] a_i,
  input  logic [DATA_W-1:0] b_i,
  output md_stat_t          stat_o,
  output logic [DATA_W-1:0] res_o
);

  localparam int DIV_STEPS = DATA_W + FRACTION_BITS;
  localparam int STEP_W    = $clog2(DIV_STEPS);

  localparam logic [1:0] P_IDLE = 2'd0;
  localparam logic [1:0] P_RUN  = 2'd1;
  localparam logic [1:0] P_FIN  = 2'd2;

  localparam logic [DATA_W-1:0] MIN_MAG = {1'b1, {(DATA_W-1){1'b0}}};

  logic [1:0]        phase_q;
  logic [STEP_W-1:0] steps_q;
  logic              done_q;
  logic              div_q, neg_q, ovf_q, ok_q;
  logic [DATA_W-1:0] acc_q, lo_q, sh_q, opnd_q, res_q;

  logic [DATA_W-1:0]   mag_a, mag_b;
  logic [DATA_W:0]     mul_sum;
  logic [DATA_W+1:0]   div_trial;
  logic                div_ge;
  logic [2*DATA_W-1:0] shifted;
  logic                hi_zero, fits;
  logic [DATA_W-1:0]   mag, signed_res;

  assign mag_a = a_i[DATA_W-1] ? (~a_i + 1'b1) : a_i;
  assign mag_b = b_i[DATA_W-1] ? (~b_i + 1'b1) : b_i;

  assign mul_sum   = {1'b0, acc_q} + (sh_q[0] ? {1'b0, opnd_q} : {(DATA_W+1){1'b0}});
  assign div_trial = {1'b0, acc_q, sh_q[DATA_W-1]} - {2'b00, opnd_q};
  assign div_ge    = ~div_trial[DATA_W+1];

  // Drop the fraction bits of the full product
  assign shifted = {acc_q, lo_q} >> FRACTION_BITS;

  always_comb begin
    if (div_q) begin
      hi_zero = ~ovf_q;
      mag     = lo_q;
    end else begin
      hi_zero = (shifted[2*DATA_W-1:DATA_W] == '0);
      mag     = shifted[DATA_W-1:0];
    end
    fits       = hi_zero && (neg_q ? (mag <= MIN_MAG) : ~mag[DATA_W-1]);
    signed_res = neg_q ? (~mag + 1'b1) : mag;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= P_IDLE;
      steps_q <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      unique case (phase_q)
        P_IDLE: begin
          if (ctrl_i.start) begin
            phase_q <= P_RUN;
            steps_q <= ctrl_i.div ? STEP_W'(DIV_STEPS - 1) : STEP_W'(DATA_W - 1);
          end
        end
        P_RUN: begin
          if (steps_q == '0) begin
            phase_q <= P_FIN;
          end else begin
            steps_q <= steps_q - 1'b1;
          end
        end
        P_FIN: begin
          phase_q <= P_IDLE;
          done_q  <= 1'b1;
        end
        default: phase_q <= P_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.start && (phase_q == P_IDLE)) begin
      div_q  <= ctrl_i.div;
      neg_q  <= a_i[DATA_W-1] ^ b_i[DATA_W-1];
      ovf_q  <= 1'b0;
      acc_q  <= '0;
      lo_q   <= '0;
      sh_q   <= ctrl_i.div ? mag_a : mag_b;
      opnd_q <= ctrl_i.div ? mag_b : mag_a;
    end else if (phase_q == P_RUN) begin
      if (div_q) begin
        acc_q <= div_ge ? div_trial[DATA_W-1:0] : {acc_q[DATA_W-2:0], sh_q[DATA_W-1]};
        lo_q  <= {lo_q[DATA_W-2:0], div_ge};
        ovf_q <= ovf_q | lo_q[DATA_W-1];
        sh_q  <= {sh_q[DATA_W-2:0], 1'b0};
      end else begin
        acc_q <= mul_sum[DATA_W:1];
        lo_q  <= {mul_sum[0], lo_q[DATA_W-1:1]};
        sh_q  <= {1'b0, sh_q[DATA_W-1:1]};
      end
    end else if (phase_q == P_FIN) begin
      res_q <= signed_res;
      ok_q  <= fits;
    end
  end

  assign stat_o.done = done_q;
  assign stat_o.ok   = ok_q;
  assign res_o       = res_q;

endmodule

// ===== rtl/rpn_checker.sv =====
// Port-level checks of the RPN stack calculator, bound to the top level.
// Depends on rpn_pkg and on the port list of rpn_stack_calculator.
module rpn_checker import rpn_pkg::*; #(
  parameter int STACK_DEPTH = DEF_STACK_DEPTH
) (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             s_axis_tvalid,
  input logic             s_axis_tready,
  input logic             m_axis_tvalid,
  input logic             m_axis_tready,
  input logic [OUT_W-1:0] m_axis_tdata
);

  // A stalled result word holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result word changed while stalled");

  // One word at a time: ready drops right after a word is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("second word taken while busy");

  // Status is one of the defined codes
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[73:71] <= ST_RANGE))
    else $error("undefined status code");

  // An empty stack shows a zero top value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (STACK_DEPTH < 128) && m_axis_tvalid && (m_axis_tdata[70:64] == 7'd0)
      |-> (m_axis_tdata[63:0] == 64'd0))
    else $error("empty stack with nonzero top value");

endmodule

bind rpn_stack_calculator rpn_checker #(
  .STACK_DEPTH (STACK_DEPTH)
) u_rpn_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

// ===== test/tb_rpn_stack_calculator.sv =====
// Self-checking testbench for rpn_stack_calculator: directed and random token streams on
// the slave stream, results on the master stream checked against an in-bench evaluator.
// Depends on rpn_pkg (widths, action and status codes) and the calculator RTL.
`timescale 1ns / 100ps

module tb_rpn_stack_calculator;
  import rpn_pkg::*;

  localparam int CLK_HALF     = 4;
  localparam int RESET_CYCLES = 12;
  // Cycles without any word moving on either side before the run is declared hung.
  // A divide and the longest back-pressure burst together take far less, so the margin is wide.
  localparam int HANG_LIMIT   = 4000;
  // Quiet cycles after the last result, longer than the slowest divide.
  localparam int SETTLE_CYCLES = 150;
  localparam int MAX_REPORTS   = 10;

  // Action codes the block treats as no operation
  localparam logic [ACT_W-1:0] ACT_SPARE_A = 3'd6;
  localparam logic [ACT_W-1:0] ACT_SPARE_B = 3'd7;

  // Q32.32 constants
  localparam logic [DATA_W-1:0] Q_MAX      = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [DATA_W-1:0] Q_MIN      = 64'h8000_0000_0000_0000;
  localparam logic [DATA_W-1:0] Q_ONE      = 64'h0000_0001_0000_0000;
  localparam logic [DATA_W-1:0] Q_MINUS1   = 64'hFFFF_FFFF_0000_0000;
  localparam logic [DATA_W-1:0] Q_HALF     = 64'h0000_0000_8000_0000;
  localparam logic [DATA_W-1:0] Q_1P5      = 64'h0000_0001_8000_0000;
  localparam logic [DATA_W-1:0] Q_2P25     = 64'h0000_0002_4000_0000;
  localparam logic [DATA_W-1:0] Q_THREE    = 64'h0000_0003_0000_0000;
  localparam logic [DATA_W-1:0] Q_MINUS2   = 64'hFFFF_FFFE_0000_0000;
  localparam logic [DATA_W-1:0] Q_MINUS3   = 64'hFFFF_FFFD_0000_0000;

  // Result word layout from bit 0 up: top value, depth, status
  typedef struct packed {
    logic [STAT_W-1:0]  status;
    logic [DEPTH_W-1:0] depth;
    logic [DATA_W-1:0]  top;
  } calc_result_t;

  logic               clk_i;
  logic               rst_ni;
  logic               s_axis_tvalid;
  logic               s_axis_tready;
  logic [DATA_W-1:0]  s_axis_tdata;   // [63:0] operand_value
  logic [ACT_W-1:0]   s_axis_tuser;   // [2:0] action
  logic               m_axis_tvalid;
  logic               m_axis_tready;
  logic [OUT_W-1:0]   m_axis_tdata;   // [63:0] top_value, [70:64] stack_depth,
                                      // [73:71] status, [79:74] zero

  // Evaluator state: operand stack, depth and sticky error
  logic [DATA_W-1:0]  calc_stack [DEF_STACK_DEPTH];
  int                 calc_depth;
  logic [STAT_W-1:0]  calc_error;

  calc_result_t       pending_results [$];
  int                 fault_count = 0;
  int                 hang_count = 0;
  bit                 idle_on;

  rpn_stack_calculator i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial clk_i = 1'b0;
  always #(CLK_HALF) clk_i = ~clk_i;

  // ------------------------------------------------------------------------------------------
  // Evaluator
  // ------------------------------------------------------------------------------------------

  function automatic logic [DATA_W-1:0] magnitude_of(logic [DATA_W-1:0] v);
    return v[DATA_W-1] ? (~v + 64'd1) : v;
  endfunction

  // Fit a 128-bit magnitude with a sign into 64 signed bits; bit 64 flags success.
  function automatic logic [DATA_W:0] fit_signed(logic [127:0] mag, bit neg);
    if (mag[127:64] != '0) return '0;
    if (neg) begin
      if (mag[63:0] > Q_MIN) return '0;
      return {1'b1, ~mag[63:0] + 64'd1};
    end
    if (mag[63]) return '0;
    return {1'b1, mag[63:0]};
  endfunction

  // Apply one token to the evaluator state and return the result word it should produce.
  function automatic calc_result_t evaluate_token(logic [ACT_W-1:0] act,
                                                  logic [DATA_W-1:0] val);
    logic [DATA_W-1:0] top_v, next_v, sum, flags;
    logic [127:0]      wide;
    logic [DATA_W:0]   fitted;
    bit                neg;
    calc_result_t      res;

    fitted = '0;
    if (act == ACT_CLEAR) begin
      calc_depth = 0;
      calc_error = ST_OK;
    end else if (calc_error == ST_OK && act <= ACT_CLEAR) begin
      if (act == ACT_PUSH) begin
        if (calc_depth >= DEF_STACK_DEPTH) begin
          calc_error = ST_FULL;
        end else begin
          calc_stack[calc_depth] = val;
          calc_depth++;
        end
      end else if (calc_depth < 2) begin
        calc_error = ST_UNDERFLOW;
      end else begin
        top_v  = calc_stack[calc_depth-1];
        next_v = calc_stack[calc_depth-2];
        neg    = top_v[DATA_W-1] ^ next_v[DATA_W-1];
        case (act)
          ACT_ADD: begin
            sum    = next_v + top_v;
            flags  = (next_v ^ sum) & (top_v ^ sum);
            fitted = {~flags[DATA_W-1], sum};
          end
          ACT_SUB: begin
            sum    = next_v - top_v;
            flags  = (next_v ^ top_v) & (next_v ^ sum);
            fitted = {~flags[DATA_W-1], sum};
          end
          ACT_MUL: begin
            wide   = {64'd0, magnitude_of(next_v)} * {64'd0, magnitude_of(top_v)};
            wide   = wide >> DEF_FRACTION_BITS;
            fitted = fit_signed(wide, neg);
          end
          default: begin
            if (top_v == '0) begin
              calc_error = ST_DIVZERO;
            end else begin
              wide   = {64'd0, magnitude_of(next_v)} << DEF_FRACTION_BITS;
              wide   = wide / {64'd0, magnitude_of(top_v)};
              fitted = fit_signed(wide, neg);
            end
          end
        endcase
        if (calc_error == ST_OK) begin
          if (!fitted[DATA_W]) begin
            calc_error = ST_RANGE;
          end else begin
            calc_depth--;
            calc_stack[calc_depth-1] = fitted[DATA_W-1:0];
          end
        end
      end
    end
    res.top    = (calc_depth > 0) ? calc_stack[calc_depth-1] : '0;
    res.depth  = DEPTH_W'(calc_depth);
    res.status = calc_error;
    return res;
  endfunction

  // ------------------------------------------------------------------------------------------
  // Slave side: one token per call. Called and left at a falling edge; tvalid stays high
  // between back-to-back words and is only dropped by an idle burst or release_tokens.
  // ------------------------------------------------------------------------------------------

  task automatic send_word(input logic [ACT_W-1:0] act, input logic [DATA_W-1:0] val);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= val;
    s_axis_tuser  <= act;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    // Word taken at this edge: predict its result
    pending_results.push_back(evaluate_token(act, val));
    @(negedge clk_i);
  endtask

  task automatic release_tokens();
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= ACT_PUSH;
  endtask

  // Hold the sender until every result is back, then give the block time to go quiet.
  task automatic drain_results();
    release_tokens();
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // ------------------------------------------------------------------------------------------
  // Master side: random back-pressure in bursts of tready-low cycles
  // ------------------------------------------------------------------------------------------

  initial begin
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (idle_on && $urandom_range(0, 7) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 12) - 1) @(negedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Compare each result word with the oldest prediction
  always @(posedge clk_i) begin
    calc_result_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = calc_result_t'(m_axis_tdata[STAT_W+DEPTH_W+DATA_W-1:0]);
      if (pending_results.size() == 0) begin
        fault_count++;
        if (fault_count <= MAX_REPORTS)
          $display("%0t: unexpected result top=%h depth=%0d status=%0d",
                   $realtime, got.top, got.depth, got.status);
      end else begin
        want = pending_results.pop_front();
        if (got.top !== want.top || got.depth !== want.depth || got.status !== want.status)
        begin
          fault_count++;
          if (fault_count <= MAX_REPORTS)
            $display("%0t: mismatch top %h/%h depth %0d/%0d status %0d/%0d (want/got)",
                     $realtime, want.top, got.top, want.depth, got.depth,
                     want.status, got.status);
        end
      end
    end
  end

  // Hang detection: count cycles in which no word moves on either side
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      hang_count <= 0;
    else
      hang_count <= hang_count + 1;
    if (hang_count >= HANG_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // ------------------------------------------------------------------------------------------
  // Operand and action choice for the random part
  // ------------------------------------------------------------------------------------------

  function automatic logic [DATA_W-1:0] rand_operand();
    logic [31:0] whole;
    whole = '0;
    case ($urandom_range(0, 9))
      0: return {$urandom, $urandom};
      1: return '0;
      2: begin
        case ($urandom_range(0, 3))
          0: return Q_MAX;
          1: return Q_MIN;
          2: return 64'd1;
          default: return '1;
        endcase
      end
      3, 4: begin
        whole = 32'($urandom_range(0, 200000)) - 32'd100000;
        return {whole, $urandom};
      end
      default: begin
        whole = 32'($urandom_range(0, 20)) - 32'd10;
        return {whole, $urandom};
      end
    endcase
  endfunction

  function automatic logic [ACT_W-1:0] rand_binary_op();
    case ($urandom_range(0, 3))
      0: return ACT_ADD;
      1: return ACT_SUB;
      2: return ACT_MUL;
      default: return ACT_DIV;
    endcase
  endfunction

  // Mostly well-formed: enough pushes to feed the operators, clear after an error,
  // with a little noise (early operators, stray clears, spare codes).
  function automatic logic [ACT_W-1:0] rand_action();
    int r;
    r = $urandom_range(0, 99);
    if (calc_error != ST_OK)
      return (r < 80) ? ACT_CLEAR : (r < 90 ? rand_binary_op() : ACT_PUSH);
    if (calc_depth < 2) begin
      if (r < 85) return ACT_PUSH;
      if (r < 93) return rand_binary_op();
      if (r < 97) return ACT_CLEAR;
      return (r[0]) ? ACT_SPARE_A : ACT_SPARE_B;
    end
    if (r < 47) return ACT_PUSH;
    if (r < 95) return rand_binary_op();
    if (r < 98) return ACT_CLEAR;
    return (r[0]) ? ACT_SPARE_A : ACT_SPARE_B;
  endfunction

  // ------------------------------------------------------------------------------------------
  // Tests
  // ------------------------------------------------------------------------------------------

  // Each operator once on plain values, the operand extremes, and a spare code
  task automatic test_arithmetic();
    send_word(ACT_PUSH, Q_1P5);
    send_word(ACT_PUSH, Q_2P25);
    send_word(ACT_ADD,  {$urandom, $urandom});
    send_word(ACT_PUSH, Q_HALF);
    send_word(ACT_SUB,  '0);
    send_word(ACT_PUSH, Q_THREE);
    send_word(ACT_MUL,  '1);
    send_word(ACT_PUSH, Q_MINUS2);
    send_word(ACT_DIV,  '0);
    send_word(ACT_PUSH, Q_MAX);
    send_word(ACT_PUSH, Q_MIN);
    send_word(ACT_ADD,  '0);
    send_word(ACT_SPARE_B, '1);
    send_word(ACT_CLEAR, '0);
  endtask

  // Underflow, divide by zero with a negative dividend, out of range on add and on
  // multiply, and sticky behaviour: words after an error change nothing until clear.
  task automatic test_error_cases();
    send_word(ACT_ADD,   '0);
    send_word(ACT_PUSH,  Q_ONE);
    send_word(ACT_CLEAR, '0);
    send_word(ACT_PUSH,  Q_MINUS3);
    send_word(ACT_PUSH,  '0);
    send_word(ACT_DIV,   '0);
    send_word(ACT_CLEAR, '0);
    send_word(ACT_PUSH,  Q_MAX);
    send_word(ACT_PUSH,  Q_ONE);
    send_word(ACT_ADD,   '0);
    send_word(ACT_CLEAR, '0);
    send_word(ACT_PUSH,  Q_MIN);
    send_word(ACT_PUSH,  Q_MINUS1);
    send_word(ACT_MUL,   '0);
    send_word(ACT_CLEAR, '0);
    send_word(ACT_SPARE_A, Q_ONE);
  endtask

  // Fill the stack to its depth, pop once, refill, then push into a full stack
  task automatic test_stack_full();
    send_word(ACT_CLEAR, '0);
    repeat (DEF_STACK_DEPTH) send_word(ACT_PUSH, rand_operand());
    send_word(ACT_ADD,   '0);
    send_word(ACT_PUSH,  rand_operand());
    send_word(ACT_PUSH,  rand_operand());
    send_word(ACT_PUSH,  rand_operand());
    send_word(ACT_CLEAR, '0);
  endtask

  // Random token stream; words the block merely ignores do not count toward the total
  task automatic test_random_tokens(input int count);
    int                done;
    logic [ACT_W-1:0]  act;
    bit                counted;
    done = 0;
    while (done < count) begin
      act     = rand_action();
      counted = (act == ACT_CLEAR) || (calc_error == ST_OK && act <= ACT_CLEAR);
      send_word(act, (act == ACT_PUSH) ? rand_operand() : {$urandom, $urandom});
      if (counted) done++;
    end
  endtask

  // ------------------------------------------------------------------------------------------
  // Sequence
  // ------------------------------------------------------------------------------------------

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = ACT_PUSH;
    idle_on       = 1'b1;
    calc_depth    = 0;
    calc_error    = ST_OK;
    foreach (calc_stack[i]) calc_stack[i] = '0;

    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_arithmetic();
    test_error_cases();
    drain_results();
    test_random_tokens(350);
    drain_results();
    test_stack_full();
    test_random_tokens(350);
    drain_results();
    // Last part runs flat out on both sides
    idle_on = 1'b0;
    test_random_tokens(300);

    drain_results();
    if (fault_count == 0 && pending_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
